>>> rtl/core/life_grid_generation_step_assert.svh
// Assertion macros used by the checker module of the life grid block.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LGS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lgs_pkg.sv
// Package with the shared constants and types of the life grid block.
package lgs_pkg;

    localparam int MAX_SIDE = 128;
    localparam int SIDE_W   = 7;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_STEP   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // Write port of one cell store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } ram_wr_t;

endpackage

>>> rtl/core/lgs_cell_ram.sv
// One-bit-wide synchronous cell store with one write and one registered read port.
module lgs_cell_ram (
    input  logic                      clk,
    input  lgs_pkg::ram_wr_t          wr,
    input  logic [lgs_pkg::ADDR_W-1:0] raddr,
    output logic                      rd_data
);
    import lgs_pkg::*;

    logic mem [CELLS];

    // Write first in program order; a read of the same entry in the same cycle sees old data.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[raddr];
    end

endmodule

>>> rtl/core/life_grid_generation_step.sv
// Top level of the toroidal life grid: two cell stores and the command sequencer.
//
// Input channel (in_valid/in_ready) carries command, column, row_index and write_value.
// Output channel (out_valid/out_ready) returns cell_value and done_command, one result
// per command. Configuration writes grid_width (index 0) and grid_height (index 1)
// through cfg_write_enable, cfg_index and cfg_data.
// A write or an unused command shows its result in the cycle after the transfer, and a
// new command can follow back to back when out_ready is high.
// A read passes through the read state before its result is shown, and holds in_ready
// low in that state, because the cell store has a registered read port; reads
// therefore cannot follow each other back to back.
// A step sweeps all 16384 entries of the next store: each cell inside the grid takes
// nine neighborhood reads over the single read port and then the write, while each
// cell outside is only written; the step result is shown after the last entry.
// While a result waits for out_ready, no new command is taken unless it is
// transferred in the same cycle.
// After reset a clearing pass writes zero into all 16384 entries of both stores, with
// in_ready low; configuration writes are still taken during that pass.
module life_grid_generation_step (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_enable,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] column,
    input  logic [6:0] row_index,
    input  logic       write_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       cell_value,
    output logic [1:0] done_command
);
    import lgs_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_STEP  = 2'd3;

    localparam logic [3:0] K_CENTER = 4'd4;
    localparam logic [3:0] K_LAST   = 4'd9;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SIDE_W-1:0] c_reg, c_next, r_reg, r_next;
    logic [3:0]        k_reg, k_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              alive_reg, alive_next;
    logic              active_reg, active_next;
    logic              rd_inside_reg, rd_inside_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_cell_reg, out_cell_next;
    logic [1:0]        out_cmd_reg, out_cmd_next;
    logic [7:0]        width_reg, height_reg;

    logic [7:0]        w_eff, h_eff;
    logic [SIDE_W-1:0] w_last, h_last;
    logic              accept, addr_in_grid, cell_in, last_cell;
    logic [SIDE_W-1:0] nb_col, nb_row;
    logic [ADDR_W-1:0] raddr;
    logic              rd_a, rd_b, cur_rd;
    logic [3:0]        n_total;
    logic              next_cell;
    ram_wr_t           wr_a, wr_b, wr_cur, wr_nxt;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd100;
            height_reg <= 8'd100;
        end
        else if (cfg_write_enable)
        begin
            if (cfg_index == CFG_GRID_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Sizes in use: zero counts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (width_reg == 8'd0)
            w_eff = 8'd1;
        else if (width_reg > 8'(MAX_SIDE))
            w_eff = 8'(MAX_SIDE);
        else
            w_eff = width_reg;
        if (height_reg == 8'd0)
            h_eff = 8'd1;
        else if (height_reg > 8'(MAX_SIDE))
            h_eff = 8'(MAX_SIDE);
        else
            h_eff = height_reg;
    end

    assign w_last = SIDE_W'(w_eff - 8'd1);
    assign h_last = SIDE_W'(h_eff - 8'd1);

    assign accept       = in_valid && in_ready;
    assign addr_in_grid = ({1'b0, column} < w_eff) && ({1'b0, row_index} < h_eff);
    assign cell_in      = ({1'b0, c_reg} < w_eff) && ({1'b0, r_reg} < h_eff);
    assign last_cell    = (c_reg == SIDE_W'(MAX_SIDE - 1)) && (r_reg == SIDE_W'(MAX_SIDE - 1));

    // Wrapped neighbor of the swept cell, numbered row by row from the upper left.
    always_comb
    begin
        case (k_reg) inside
            4'd0, 4'd3, 4'd6: nb_col = (c_reg == '0) ? w_last : c_reg - 1'b1;
            4'd2, 4'd5, 4'd8: nb_col = (c_reg == w_last) ? '0 : c_reg + 1'b1;
            default:          nb_col = c_reg;
        endcase
        case (k_reg) inside
            [4'd0:4'd2]: nb_row = (r_reg == '0) ? h_last : r_reg - 1'b1;
            [4'd6:4'd8]: nb_row = (r_reg == h_last) ? '0 : r_reg + 1'b1;
            default:     nb_row = r_reg;
        endcase
    end

    assign raddr = (state_reg == ST_STEP) ? {nb_row, nb_col} : {row_index, column};

    // Cell stores; the active one holds the current generation.
    lgs_cell_ram u_store_a (
        .clk     (clk),
        .wr      (wr_a),
        .raddr   (raddr),
        .rd_data (rd_a)
    );

    lgs_cell_ram u_store_b (
        .clk     (clk),
        .wr      (wr_b),
        .raddr   (raddr),
        .rd_data (rd_b)
    );

    assign cur_rd = active_reg ? rd_b : rd_a;

    // Neighbor total including the last read, and the rule for the next generation.
    assign n_total   = cnt_reg + {3'd0, cur_rd};
    assign next_cell = alive_reg ? (n_total == 4'd2 || n_total == 4'd3) : (n_total == 4'd3);

    // Sequencer for clearing, commands and the generation sweep.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        alive_next     = alive_reg;
        active_next    = active_reg;
        rd_inside_next = rd_inside_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cell_next  = out_cell_reg;
        out_cmd_next   = out_cmd_reg;
        wr_cur         = '{we: 1'b0, addr: {row_index, column}, data: write_value};
        wr_nxt         = '{we: 1'b0, addr: {r_reg, c_reg}, data: 1'b0};
        in_ready       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (accept)
                begin
                    case (command)
                        CMD_WRITE:
                        begin
                            wr_cur.we      = addr_in_grid;
                            out_valid_next = 1'b1;
                            out_cell_next  = 1'b0;
                            out_cmd_next   = command;
                        end
                        CMD_READ:
                        begin
                            rd_inside_next = addr_in_grid;
                            state_next     = ST_READ;
                        end
                        CMD_STEP:
                        begin
                            c_next     = '0;
                            r_next     = '0;
                            k_next     = '0;
                            cnt_next   = '0;
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_cell_next  = 1'b0;
                            out_cmd_next   = command;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_cell_next  = rd_inside_reg && cur_rd;
                out_cmd_next   = CMD_READ;
                state_next     = ST_IDLE;
            end
            default:
            begin
                // Write the cell: dead outside the grid, else its next state.
                if (!cell_in || k_reg == K_LAST)
                begin
                    wr_nxt.we   = 1'b1;
                    wr_nxt.data = cell_in && next_cell;
                    k_next      = '0;
                    cnt_next    = '0;
                    if (last_cell)
                    begin
                        active_next    = !active_reg;
                        out_valid_next = 1'b1;
                        out_cell_next  = 1'b0;
                        out_cmd_next   = CMD_STEP;
                        state_next     = ST_IDLE;
                    end
                    else if (c_reg == SIDE_W'(MAX_SIDE - 1))
                    begin
                        c_next = '0;
                        r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    // Read data arriving now belongs to the neighbor issued last cycle.
                    k_next = k_reg + 1'b1;
                    if (k_reg == K_CENTER + 4'd1)
                    begin
                        alive_next = cur_rd;
                    end
                    else if (k_reg != 4'd0)
                    begin
                        cnt_next = cnt_reg + {3'd0, cur_rd};
                    end
                end
            end
        endcase
    end

    // Route the write ports: both stores while clearing, else current or next store.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_a = '{we: 1'b1, addr: clr_cnt_reg, data: 1'b0};
            wr_b = wr_a;
        end
        else if (state_reg == ST_STEP)
        begin
            wr_a = active_reg ? wr_nxt : '{we: 1'b0, addr: wr_nxt.addr, data: 1'b0};
            wr_b = active_reg ? '{we: 1'b0, addr: wr_nxt.addr, data: 1'b0} : wr_nxt;
        end
        else
        begin
            wr_a = active_reg ? '{we: 1'b0, addr: wr_cur.addr, data: 1'b0} : wr_cur;
            wr_b = active_reg ? wr_cur : '{we: 1'b0, addr: wr_cur.addr, data: 1'b0};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    // Payload and sweep registers.
    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        r_reg         <= r_next;
        cnt_reg       <= cnt_next;
        alive_reg     <= alive_next;
        rd_inside_reg <= rd_inside_next;
        out_cell_reg  <= out_cell_next;
        out_cmd_reg   <= out_cmd_next;
    end

    assign out_valid    = out_valid_reg;
    assign cell_value   = out_cell_reg;
    assign done_command = out_cmd_reg;

endmodule

>>> rtl/core/lgs_checker.sv
// Port-level checker for the life grid block and its bind to the top level.
`include "life_grid_generation_step_assert.svh"

module lgs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_ready,
    input logic       cell_value,
    input logic [1:0] done_command
);
    import lgs_pkg::*;

    // A stalled result stays offered.
    `LGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Only a read can return a live cell.
    `LGS_ASSERT_NOW(a_cell_zero, out_valid && done_command != CMD_READ, !cell_value, "cell value set for a non-read command")

    // A write completes in the next cycle.
    `LGS_ASSERT_NEXT(a_write_done, in_valid && in_ready && command == CMD_WRITE, out_valid && done_command == CMD_WRITE, "write result missing")

    // A step holds off the input channel in the following cycle.
    `LGS_ASSERT_NEXT(a_step_busy, in_valid && in_ready && command == CMD_STEP, !in_ready, "input taken during a step")

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_value   (cell_value),
    .done_command (done_command)
);

>>> tb/tb_life_grid_generation_step.sv
// Testbench for the toroidal life grid: cell writes, reads, generation steps and size settings.
module tb_life_grid_generation_step;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_enable;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [6:0] column;
    logic [6:0] row_index;
    logic       write_value;
    logic       out_valid;
    logic       out_ready;
    logic       cell_value;
    logic [1:0] done_command;

    typedef struct packed {
        logic       cell_bit;
        logic [1:0] cmd;
    } grid_result_t;

    // Mirror of the block state.
    logic         mirror_grid [2][MAX_SIDE][MAX_SIDE];
    logic         mirror_active;
    logic [7:0]   width_reg;
    logic [7:0]   height_reg;
    grid_result_t pending_results[$];
    int           error_count;
    int           result_count;
    int           step_count;
    bit           sink_quiet;

    life_grid_generation_step i_dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int used_side(logic [7:0] v);
        if (v == 8'd0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    // Compute the next generation into the other buffer and swap.
    function automatic void advance_mirror();
        int w;
        int h;
        int n;
        logic cur;
        logic nxt;
        w = used_side(width_reg);
        h = used_side(height_reg);
        cur = mirror_active;
        nxt = ~mirror_active;
        for (int r = 0; r < MAX_SIDE; r++)
        begin
            for (int c = 0; c < MAX_SIDE; c++)
            begin
                mirror_grid[nxt][r][c] = 1'b0;
                if (r < h && c < w)
                begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                    begin
                        for (int dc = -1; dc <= 1; dc++)
                        begin
                            if (dr != 0 || dc != 0)
                                n += mirror_grid[cur][(r + dr + h) % h][(c + dc + w) % w];
                        end
                    end
                    if (mirror_grid[cur][r][c])
                        mirror_grid[nxt][r][c] = (n == 2 || n == 3);
                    else
                        mirror_grid[nxt][r][c] = (n == 3);
                end
            end
        end
        mirror_active = nxt;
    endfunction

    function automatic grid_result_t predict_command(logic [1:0] cmd, logic [6:0] col,
                                                     logic [6:0] row, logic val);
        grid_result_t res;
        bit in_grid;
        in_grid = (col < used_side(width_reg)) && (row < used_side(height_reg));
        res.cell_bit = 1'b0;
        res.cmd = cmd;
        case (cmd)
            CMD_WRITE:
                if (in_grid) mirror_grid[mirror_active][row][col] = val;
            CMD_READ:
                if (in_grid) res.cell_bit = mirror_grid[mirror_active][row][col];
            CMD_STEP:
                advance_mirror();
            default: ;
        endcase
        return res;
    endfunction

    // Send one command; the expectation is queued at the transfer edge.
    // Valid stays high afterwards so that the next command can follow back to back.
    task automatic send_command(logic [1:0] cmd, logic [6:0] col, logic [6:0] row,
                                logic val, bit allow_gap = 1'b1);
        if (allow_gap)
        begin
            while ($urandom_range(99) < 7)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        command <= cmd;
        column <= col;
        row_index <= row;
        write_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_command(cmd, col, row, val));
        if (cmd == CMD_STEP) step_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Registers are written only while the block is idle.
    task automatic write_size(logic [7:0] w, logic [7:0] h);
        drain();
        cfg_write_enable <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        grid_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: cell_value %0d done_command %0d",
                       cell_value, done_command);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_value !== want.cell_bit)
                begin
                    $error("cell_value: expected %0d, actual %0d", want.cell_bit, cell_value);
                    error_count++;
                end
                if (done_command !== want.cmd)
                begin
                    $error("done_command: expected %0d, actual %0d", want.cmd, done_command);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls at random, except during a quiet stretch.
    always @(negedge clk)
    begin
        if (!rst_n || sink_quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 7);
    end

    task automatic test_directed_small();
        write_size(8'd6, 8'd5);
        // Blinker at rows 1..3, column 2, with a read outside the grid.
        send_command(CMD_WRITE, 7'd2, 7'd1, 1'b1);
        send_command(CMD_WRITE, 7'd2, 7'd2, 1'b1);
        send_command(CMD_WRITE, 7'd2, 7'd3, 1'b1);
        send_command(CMD_WRITE, 7'd6, 7'd0, 1'b1);
        send_command(CMD_READ, 7'd6, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd2, 7'd2, 1'b0);
        send_command(CMD_STEP, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd1, 7'd2, 1'b0);
        send_command(CMD_READ, 7'd2, 7'd1, 1'b0);
        send_command(CMD_UNUSED, 7'd127, 7'd127, 1'b1);
        send_command(CMD_STEP, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd2, 7'd3, 1'b0);
        send_command(CMD_WRITE, 7'd2, 7'd2, 1'b0);
        send_command(CMD_READ, 7'd2, 7'd2, 1'b0);
    endtask

    task automatic test_tiny_grids();
        // Side zero acts as one, so a cell counts itself eight times.
        write_size(8'd0, 8'd0);
        send_command(CMD_WRITE, 7'd0, 7'd0, 1'b1);
        send_command(CMD_STEP, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd0, 7'd0, 1'b0);
        write_size(8'd2, 8'd1);
        send_command(CMD_WRITE, 7'd1, 7'd0, 1'b1);
        send_command(CMD_WRITE, 7'd0, 7'd0, 1'b1);
        send_command(CMD_STEP, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd1, 7'd0, 1'b0);
    endtask

    task automatic test_full_size();
        // Widths above the maximum clamp; extremes of both address fields.
        write_size(8'd255, 8'd128);
        send_command(CMD_WRITE, 7'd127, 7'd127, 1'b1);
        send_command(CMD_WRITE, 7'd0, 7'd127, 1'b1);
        send_command(CMD_WRITE, 7'd127, 7'd0, 1'b1);
        send_command(CMD_READ, 7'd127, 7'd127, 1'b0);
        send_command(CMD_STEP, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd0, 7'd0, 1'b0);
        send_command(CMD_READ, 7'd127, 7'd127, 1'b0);
    endtask

    // Random phases: mostly in-grid writes and reads, a few steps.
    task automatic test_random_phase(logic [7:0] w, logic [7:0] h, int count, bit hold_off);
        int cw;
        int ch;
        int pick;
        logic [1:0] cmd;
        write_size(w, h);
        cw = used_side(w);
        ch = used_side(h);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45) cmd = CMD_WRITE;
            else if (pick < 90) cmd = CMD_READ;
            else if (pick < 96) cmd = CMD_STEP;
            else cmd = CMD_UNUSED;
            if ($urandom_range(9) == 0)
                send_command(cmd, 7'($urandom), 7'($urandom), 1'($urandom));
            else
                send_command(cmd, 7'($urandom_range(cw - 1)), 7'($urandom_range(ch - 1)),
                             ($urandom_range(2) != 0));
            if (hold_off && i == count / 2)
                drain();
        end
    endtask

    task automatic test_quiet_stretch();
        // Back-to-back traffic with no gaps from the sender and no stalls from the receiver.
        write_size(8'd4, 8'd4);
        sink_quiet = 1'b1;
        for (int i = 0; i < 60; i++)
            send_command(($urandom_range(1) != 0) ? CMD_READ : CMD_WRITE,
                         7'($urandom_range(3)), 7'($urandom_range(3)), 1'($urandom), 1'b0);
        drain();
        sink_quiet = 1'b0;
    endtask

    initial
    begin
        for (int b = 0; b < 2; b++)
            for (int r = 0; r < MAX_SIDE; r++)
                for (int c = 0; c < MAX_SIDE; c++)
                    mirror_grid[b][r][c] = 1'b0;
        mirror_active = 1'b0;
        width_reg = 8'd100;
        height_reg = 8'd100;
        error_count = 0;
        result_count = 0;
        step_count = 0;
        sink_quiet = 1'b0;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        command = CMD_WRITE;
        column = 7'd0;
        row_index = 7'd0;
        write_value = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_small();
        test_tiny_grids();
        test_full_size();
        test_quiet_stretch();
        test_random_phase(8'd5, 8'd3, 200, 1'b1);
        test_random_phase(8'd1, 8'd7, 120, 1'b0);
        test_random_phase(8'd12, 8'd9, 200, 1'b1);
        test_random_phase(8'd3, 8'd2, 120, 1'b0);
        drain();
        repeat (20) @(negedge clk);

        $display("Covered %0d results including %0d generation steps,", result_count,
                 step_count);
        $display("over grid sizes from one cell up to the full clamped grid.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: bounds the clearing pass, the generation steps and the command traffic of all tests.
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
